FILE: src/cda_pkg.sv
// ----------------------------------------------------------------------------
// cda_pkg
// Shared types, constants and the month length table for the date adder.
// ----------------------------------------------------------------------------
package cda_pkg;

    localparam int MAX_YEAR_DEFAULT = 9999;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int COUNT_W = 16;
    // running day value during a walk: day plus or minus a full count
    localparam int WDAY_W  = 18;

    // year / 100 by reciprocal, exact for every 14-bit year
    localparam int DIV100_MULT  = 5243;
    localparam int DIV100_SHIFT = 19;
    localparam int PROD_W       = 27;
    localparam int CENT_W       = 8;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_ADD  = 2'd1,
        OP_SUB  = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD_MUL,
        ST_LOAD_CHK,
        ST_WALK,
        ST_DONE
    } state_t;

    // date being walked, with year mod 100 and centuries mod 4 for the leap rule
    typedef struct packed {
        logic [YEAR_W-1:0]        year;
        logic [MONTH_W-1:0]       month;
        logic signed [WDAY_W-1:0] day;
        logic [6:0]               mod100;
        logic [1:0]               cent;
    } walk_t;

    typedef struct packed {
        logic done;
        logic fail;
    } step_status_t;

    function automatic logic is_leap(input logic [YEAR_W-1:0] year,
                                     input logic [6:0] mod100,
                                     input logic [1:0] cent);
        logic by4;
        by4 = (year[1:0] == 2'd0);
        return (by4 && (mod100 != 7'd0)) || ((mod100 == 7'd0) && (cent == 2'd0));
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic leap,
                                                   input logic [MONTH_W-1:0] month);
        logic [DAY_W-1:0] len;
        unique case (month)
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            MONTH_FEB:               len = leap ? 5'd29 : 5'd28;
            default:                 len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

FILE: src/cda_if.sv
// ----------------------------------------------------------------------------
// cda_if
// Valid/ready channels for date adder requests and results.
// ----------------------------------------------------------------------------
interface cda_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         op;
    logic [13:0]        load_year;
    logic [3:0]         load_month;
    logic [4:0]         load_day;
    logic signed [15:0] day_count;

    modport source (output valid, op, load_year, load_month, load_day, day_count,
                    input ready);
    modport sink   (input valid, op, load_year, load_month, load_day, day_count,
                    output ready);
endinterface

interface cda_out_if;
    logic        valid;
    logic        ready;
    logic [13:0] out_year;
    logic [3:0]  out_month;
    logic [4:0]  out_day;
    logic        bad_load;
    logic        range_error;

    modport source (output valid, out_year, out_month, out_day, bad_load, range_error,
                    input ready);
    modport sink   (input valid, out_year, out_month, out_day, bad_load, range_error,
                     output ready);
endinterface

FILE: src/cda_year_split.sv
// ----------------------------------------------------------------------------
// cda_year_split
// Splits a year into year mod 100 and centuries mod 4, one register stage.
// ----------------------------------------------------------------------------
module cda_year_split
    import cda_pkg::*;
(
    input  logic              clk,
    input  logic [YEAR_W-1:0] year,
    output logic [6:0]        mod100,
    output logic [1:0]        cent
);

    logic [PROD_W-1:0] prod;
    logic [YEAR_W-1:0] year_reg;
    logic [CENT_W-1:0] q_reg;
    logic [YEAR_W-1:0] rem;

    assign prod = PROD_W'(year) * PROD_W'(DIV100_MULT);

    always_ff @(posedge clk)
    begin
        year_reg <= year;
        q_reg    <= prod[DIV100_SHIFT +: CENT_W];
    end

    assign rem    = year_reg - YEAR_W'(q_reg) * YEAR_W'(100);
    assign mod100 = rem[6:0];
    assign cent   = q_reg[1:0];

endmodule

FILE: src/cda_month_step.sv
// ----------------------------------------------------------------------------
// cda_month_step
// One carry or borrow of a whole month on the date being walked.
// ----------------------------------------------------------------------------
module cda_month_step
    import cda_pkg::*;
#(
    parameter int MAX_YEAR = MAX_YEAR_DEFAULT
)
(
    input  walk_t        cur,
    output walk_t        nxt,
    output step_status_t status
);

    logic                     leap;
    logic [DAY_W-1:0]         len_cur;
    logic [DAY_W-1:0]         len_prev;
    logic signed [WDAY_W-1:0] len_cur_s;
    logic signed [WDAY_W-1:0] len_prev_s;

    always_comb
    begin
        leap       = is_leap(cur.year, cur.mod100, cur.cent);
        len_cur    = month_len(leap, cur.month);
        // previous month is in the same year unless we wrap back to december
        len_prev   = (cur.month == MONTH_JAN) ? 5'd31 : month_len(leap, cur.month - 4'd1);
        len_cur_s  = $signed(WDAY_W'(len_cur));
        len_prev_s = $signed(WDAY_W'(len_prev));

        nxt    = cur;
        status = '0;
        priority if (cur.day > len_cur_s)
        begin
            nxt.day = cur.day - len_cur_s;
            if (cur.month == MONTH_DEC)
            begin
                if (cur.year >= YEAR_W'(MAX_YEAR))
                begin
                    status.fail = 1'b1;
                end
                nxt.month = MONTH_JAN;
                nxt.year  = cur.year + 14'd1;
                if (cur.mod100 == 7'd99)
                begin
                    nxt.mod100 = 7'd0;
                    nxt.cent   = cur.cent + 2'd1;
                end
                else
                begin
                    nxt.mod100 = cur.mod100 + 7'd1;
                end
            end
            else
            begin
                nxt.month = cur.month + 4'd1;
            end
        end
        else if (cur.day < $signed(WDAY_W'(1)))
        begin
            nxt.day = cur.day + len_prev_s;
            if (cur.month == MONTH_JAN)
            begin
                if (cur.year == '0)
                begin
                    status.fail = 1'b1;
                end
                nxt.month = MONTH_DEC;
                nxt.year  = cur.year - 14'd1;
                if (cur.mod100 == 7'd0)
                begin
                    nxt.mod100 = 7'd99;
                    nxt.cent   = cur.cent - 2'd1;
                end
                else
                begin
                    nxt.mod100 = cur.mod100 - 7'd1;
                end
            end
            else
            begin
                nxt.month = cur.month - 4'd1;
            end
        end
        else
        begin
            status.done = 1'b1;
        end
    end

endmodule

FILE: src/calendar_date_add_days.sv
// ----------------------------------------------------------------------------
// calendar_date_add_days
// Holds a Gregorian date; loads a checked date or moves it by a signed count.
// ----------------------------------------------------------------------------
// Usage: requests arrive on the item channel (valid/ready). op 0 loads
// load_year/load_month/load_day after checking them against the calendar;
// op 1 adds day_count days, op 2 subtracts it; op 3 only reports the date.
// Every request produces one word on the result channel with the held date
// and the bad_load / range_error flags. A move that would leave years
// 0..MAX_YEAR keeps the date and raises range_error.
// Timing: a load passes through LOAD_MUL and LOAD_CHK between accept and
// result valid; a move carries or borrows one month per step, up to about
// 1100 months for the largest count. The month walk reuses a single
// carry/borrow step, one month per cycle, which sets the rate.
// The block accepts one request at a time: item.ready is high only while
// idle, and stays low until the result word has been taken, so a stalled
// receiver simply holds the result and the next request waits.
// Reset puts the held date at year 0, January 1, with the channels idle.
// ----------------------------------------------------------------------------
module calendar_date_add_days
    import cda_pkg::*;
#(
    parameter int MAX_YEAR = MAX_YEAR_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    cda_in_if.sink    item,
    cda_out_if.source result
);

    state_t state_reg, state_next;

    logic [YEAR_W-1:0]  cur_year_reg;
    logic [MONTH_W-1:0] cur_month_reg;
    logic [DAY_W-1:0]   cur_day_reg;
    logic [6:0]         cur_mod100_reg;
    logic [1:0]         cur_cent_reg;
    logic               bad_reg;
    logic               rerr_reg;

    logic [YEAR_W-1:0]  ld_year_reg;
    logic [MONTH_W-1:0] ld_month_reg;
    logic [DAY_W-1:0]   ld_day_reg;

    walk_t        walk_reg;
    walk_t        walk_step;
    step_status_t step_status;

    logic [6:0]               split_mod100;
    logic [1:0]               split_cent;
    logic                     ld_leap;
    logic                     ld_bad;
    logic                     accept;
    logic signed [WDAY_W-1:0] count_ext;
    logic signed [WDAY_W-1:0] start_day;

    cda_year_split u_split (
        .clk    (clk),
        .year   (ld_year_reg),
        .mod100 (split_mod100),
        .cent   (split_cent)
    );

    cda_month_step #(
        .MAX_YEAR (MAX_YEAR)
    ) u_step (
        .cur    (walk_reg),
        .nxt    (walk_step),
        .status (step_status)
    );

    assign accept = item.valid && item.ready;

    // load check
    always_comb
    begin
        ld_leap = is_leap(ld_year_reg, split_mod100, split_cent);
        ld_bad  = (ld_year_reg > YEAR_W'(MAX_YEAR)) || (ld_month_reg == '0) ||
                  (ld_month_reg > MONTH_DEC) || (ld_day_reg == '0) ||
                  (ld_day_reg > month_len(ld_leap, ld_month_reg));
    end

    // starting day of a move, count negated for subtract
    always_comb
    begin
        count_ext = WDAY_W'(item.day_count);
        if (item.op == OP_SUB)
        begin
            start_day = $signed(WDAY_W'(cur_day_reg)) - count_ext;
        end
        else
        begin
            start_day = $signed(WDAY_W'(cur_day_reg)) + count_ext;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    priority if (item.op == OP_LOAD)
                    begin
                        state_next = ST_LOAD_MUL;
                    end
                    else if (item.op == OP_ADD || item.op == OP_SUB)
                    begin
                        state_next = ST_WALK;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_LOAD_MUL: state_next = ST_LOAD_CHK;
            ST_LOAD_CHK: state_next = ST_DONE;
            ST_WALK:
            begin
                if (step_status.done || step_status.fail)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (result.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        item.ready         = (state_reg == ST_IDLE);
        result.valid       = (state_reg == ST_DONE);
        result.out_year    = cur_year_reg;
        result.out_month   = cur_month_reg;
        result.out_day     = cur_day_reg;
        result.bad_load    = bad_reg;
        result.range_error = rerr_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cur_year_reg   <= '0;
            cur_month_reg  <= MONTH_JAN;
            cur_day_reg    <= 5'd1;
            cur_mod100_reg <= '0;
            cur_cent_reg   <= '0;
            bad_reg        <= 1'b0;
            rerr_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                bad_reg  <= 1'b0;
                rerr_reg <= 1'b0;
            end
            if (state_reg == ST_LOAD_CHK)
            begin
                if (ld_bad)
                begin
                    bad_reg <= 1'b1;
                end
                else
                begin
                    cur_year_reg   <= ld_year_reg;
                    cur_month_reg  <= ld_month_reg;
                    cur_day_reg    <= ld_day_reg;
                    cur_mod100_reg <= split_mod100;
                    cur_cent_reg   <= split_cent;
                end
            end
            if (state_reg == ST_WALK)
            begin
                if (step_status.fail)
                begin
                    rerr_reg <= 1'b1;
                end
                else if (step_status.done)
                begin
                    cur_year_reg   <= walk_reg.year;
                    cur_month_reg  <= walk_reg.month;
                    cur_day_reg    <= walk_reg.day[DAY_W-1:0];
                    cur_mod100_reg <= walk_reg.mod100;
                    cur_cent_reg   <= walk_reg.cent;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ld_year_reg     <= item.load_year;
            ld_month_reg    <= item.load_month;
            ld_day_reg      <= item.load_day;
            walk_reg.year   <= cur_year_reg;
            walk_reg.month  <= cur_month_reg;
            walk_reg.day    <= start_day;
            walk_reg.mod100 <= cur_mod100_reg;
            walk_reg.cent   <= cur_cent_reg;
        end
        else if (state_reg == ST_WALK)
        begin
            walk_reg <= walk_step;
        end
    end

endmodule
